// ===== hw/rtl/polygon_vertex_consistency_check_core_macros.svh =====
// Assertion helpers shared by the checker RTL.
`ifndef POLYGON_VERTEX_CONSISTENCY_CHECK_CORE_MACROS_SVH
`define POLYGON_VERTEX_CONSISTENCY_CHECK_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property c holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (c)) \
    else $error("assertion failed");
// When a holds, c holds in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
    else $error("assertion failed");
// When a holds, c holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, c)
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

// ===== hw/rtl/pvcc_pkg.sv =====
`timescale 1ns / 1ps

package pvcc_pkg;

  localparam int LONW   = 30;           // longitude field and registers
  localparam int LATW   = 28;           // latitude field and registers
  localparam int XW     = LONW + 1;     // wrapped longitude
  localparam int YBW    = 30;           // latitude bounds, hold +-360 deg at polygon start
  localparam int DXW    = XW + 1;
  localparam int DYW    = LATW + 1;
  localparam int PW     = DXW + DYW;
  localparam int IW     = 20;           // reported vertex index
  localparam int KINDW  = 3;
  localparam int MASKW  = 7;            // one bit per possible report of a vertex
  localparam int MBW    = $clog2(MASKW);
  localparam int CFGIW  = 3;
  localparam int CFGDW  = 30;
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int DEF_MAX_VERTICES = 1048576;

  localparam logic signed [XW-1:0]  FULL_TURN_X = XW'(360000000);
  localparam logic signed [YBW-1:0] FULL_TURN_Y = YBW'(360000000);
  localparam logic signed [YBW-1:0] SOUTH_POLE  = YBW'(-90000000);

  typedef enum logic [CFGIW-1:0] {
    CFG_WRAP_ENABLE    = 3'd0,
    CFG_DATE_LONGITUDE = 3'd1,
    CFG_BOX_WEST       = 3'd2,
    CFG_BOX_EAST       = 3'd3,
    CFG_BOX_SOUTH      = 3'd4,
    CFG_BOX_NORTH      = 3'd5,
    CFG_POLAR_CAP      = 3'd6,
    CFG_REGION_CHECK   = 3'd7
  } cfg_reg_t;

  typedef enum logic [KINDW-1:0] {
    RPT_DUPLICATE    = 3'd0,
    RPT_NON_AREA     = 3'd1,
    RPT_ZERO_ANGLE   = 3'd2,
    RPT_NOT_CLOSED   = 3'd3,
    RPT_BOX_MISMATCH = 3'd4
  } rpt_kind_t;

  // Report mask bit positions, in delivery order.
  localparam logic [MBW-1:0] MB_DUP   = MBW'(0);
  localparam logic [MBW-1:0] MB_OPEN  = MBW'(1);
  localparam logic [MBW-1:0] MB_BOX   = MBW'(2);
  localparam logic [MBW-1:0] MB_V0_NA = MBW'(3);
  localparam logic [MBW-1:0] MB_V0_ZA = MBW'(4);
  localparam logic [MBW-1:0] MB_PV_NA = MBW'(5);
  localparam logic [MBW-1:0] MB_PV_ZA = MBW'(6);

  typedef struct packed {
    logic                   wrap_enable;
    logic signed [LONW-1:0] date_longitude;
    logic signed [LONW-1:0] box_west;
    logic signed [LONW-1:0] box_east;
    logic signed [LATW-1:0] box_south;
    logic signed [LATW-1:0] box_north;
    logic                   polar_cap;
    logic                   region_check;
  } cfg_t;

  typedef struct packed {
    logic signed [DXW-1:0] dx1;
    logic signed [DXW-1:0] dx2;
    logic signed [DYW-1:0] dy1;
    logic signed [DYW-1:0] dy2;
  } delta_t;

  typedef struct packed {
    logic          valid;
    logic [IW-1:0] idx;
    logic          dup;
    logic          open;
    logic          box;
    logic          v0_en;
    logic          pv_en;
  } flags_t;

  typedef struct packed {
    logic [MASKW-1:0] mask;
    logic [IW-1:0]    idx;
  } rpt_entry_t;

  typedef struct packed {
    rpt_kind_t     kind;
    logic [IW-1:0] left;
    logic [IW-1:0] center;
    logic [IW-1:0] right;
  } rpt_fields_t;

  function automatic rpt_fields_t decode_report(input logic [MBW-1:0] pos,
                                                input logic [IW-1:0]  idx);
    rpt_fields_t f;
    f.kind   = RPT_DUPLICATE;
    f.left   = '0;
    f.center = idx;
    f.right  = '0;
    unique case (pos)
      MB_DUP:   f.kind = RPT_DUPLICATE;
      MB_OPEN:  f.kind = RPT_NOT_CLOSED;
      MB_BOX:   f.kind = RPT_BOX_MISMATCH;
      MB_V0_NA, MB_V0_ZA: begin
        f.kind   = (pos == MB_V0_NA) ? RPT_NON_AREA : RPT_ZERO_ANGLE;
        f.left   = idx - IW'(1);
        f.center = '0;
        f.right  = IW'(1);
      end
      MB_PV_NA, MB_PV_ZA: begin
        f.kind   = (pos == MB_PV_NA) ? RPT_NON_AREA : RPT_ZERO_ANGLE;
        f.left   = idx - IW'(2);
        f.center = idx - IW'(1);
        f.right  = idx;
      end
      default: f.kind = RPT_DUPLICATE;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/pvcc_in_if.sv =====
`timescale 1ns / 1ps

interface pvcc_in_if import pvcc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [LONW-1:0] lon_micro;
  logic signed [LATW-1:0] lat_micro;
  logic                   first_vertex;
  logic                   final_vertex;

  modport source (output valid, lon_micro, lat_micro, first_vertex, final_vertex,
                  input ready);
  modport sink   (input valid, lon_micro, lat_micro, first_vertex, final_vertex,
                  output ready);
endinterface

// ===== hw/rtl/pvcc_out_if.sv =====
`timescale 1ns / 1ps

interface pvcc_out_if import pvcc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [KINDW-1:0] report_kind;
  logic [IW-1:0]    left_index;
  logic [IW-1:0]    center_index;
  logic [IW-1:0]    right_index;
  logic             run_end;

  modport source (output valid, report_kind, left_index, center_index, right_index,
                  run_end, input ready);
  modport sink   (input valid, report_kind, left_index, center_index, right_index,
                  run_end, output ready);
endinterface

// ===== hw/rtl/pvcc_track.sv =====
`timescale 1ns / 1ps
`include "polygon_vertex_consistency_check_core_macros.svh"

module pvcc_track import pvcc_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   in_fire,
  input  logic signed [LONW-1:0] in_lon,
  input  logic signed [LATW-1:0] in_lat,
  input  logic                   in_first,
  input  logic                   in_fin,
  output logic [1:0]             busy,
  output flags_t                 s2_flags,
  output delta_t                 s2_v0,
  output delta_t                 s2_pv
);

  localparam int CW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_VERTICES - 1);

  // stage 0: input register
  logic                   v0_r;
  logic signed [LONW-1:0] lon0_r;
  logic signed [LATW-1:0] lat0_r;
  logic                   first0_r, fin0_r;

  // stage 1: wrapped vertex
  logic                   v1_r;
  logic signed [XW-1:0]   x1_r, x1_nxt, lon_ext;
  logic signed [LATW-1:0] y1_r;
  logic                   first1_r, fin1_r;

  // polygon state
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic signed [XW-1:0]   sx_r, scx_r, px0_r, px1_r, minx_r, maxx_r;
  logic signed [LATW-1:0] sy_r, scy_r, py0_r, py1_r;
  logic signed [YBW-1:0]  miny_r, maxy_r;

  // stage 2 working values
  logic                   first, idx_is1, fin;
  logic [CW-1:0]          idx;
  logic [IW+CW-1:0]       idx_wide;
  logic signed [XW-1:0]   sx_cur, scx_cur, minx_b, maxx_b, minx_n, maxx_n;
  logic signed [LATW-1:0] sy_cur, scy_cur;
  logic signed [YBW-1:0]  y_ext, miny_b, maxy_b, miny_n, maxy_n, ymin;
  flags_t                 flags_nxt, s2_flags_r;
  delta_t                 v0_nxt, pv_nxt, s2_v0_r, s2_pv_r;

  assign lon_ext = XW'(lon0_r);
  assign x1_nxt  = (cfg.wrap_enable && (lon0_r > cfg.date_longitude)) ?
                   lon_ext - FULL_TURN_X : lon_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_fire;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lon0_r   <= in_lon;
      lat0_r   <= in_lat;
      first0_r <= in_first;
      fin0_r   <= in_fin;
    end
    if (v0_r) begin
      x1_r     <= x1_nxt;
      y1_r     <= lat0_r;
      first1_r <= first0_r;
      fin1_r   <= fin0_r;
    end
  end

  always_comb begin
    first    = first1_r || (cnt_r == '0);
    fin      = fin1_r;
    idx      = first ? '0 : cnt_r;
    idx_is1  = (idx == CW'(1));
    idx_wide = {{IW{1'b0}}, idx};
    y_ext    = YBW'(y1_r);

    sx_cur  = first ? x1_r : sx_r;
    sy_cur  = first ? y1_r : sy_r;
    scx_cur = idx_is1 ? x1_r : scx_r;
    scy_cur = idx_is1 ? y1_r : scy_r;

    // a new polygon restarts the box from the empty bounds
    minx_b = first ? FULL_TURN_X  : minx_r;
    maxx_b = first ? -FULL_TURN_X : maxx_r;
    miny_b = first ? FULL_TURN_Y  : miny_r;
    maxy_b = first ? -FULL_TURN_Y : maxy_r;
    minx_n = (x1_r < minx_b) ? x1_r : minx_b;
    maxx_n = (x1_r > maxx_b) ? x1_r : maxx_b;
    miny_n = (y_ext < miny_b) ? y_ext : miny_b;
    maxy_n = (y_ext > maxy_b) ? y_ext : maxy_b;
    ymin   = cfg.polar_cap ? SOUTH_POLE : miny_n;

    flags_nxt.valid = v1_r;
    flags_nxt.idx   = idx_wide[IW-1:0];
    flags_nxt.dup   = (idx != '0) && (x1_r == px0_r) && (y1_r == py0_r);
    flags_nxt.open  = fin && !((x1_r == sx_cur) && (y1_r == sy_cur));
    flags_nxt.box   = fin && cfg.region_check &&
                      !((minx_n == XW'(cfg.box_west)) && (maxx_n == XW'(cfg.box_east)) &&
                        (ymin == YBW'(cfg.box_south)) && (maxy_n == YBW'(cfg.box_north)));
    flags_nxt.v0_en = fin && (idx != '0);
    flags_nxt.pv_en = (idx > CW'(1));

    // check centered on vertex 0: previous vertex, start, second
    v0_nxt.dx1 = DXW'(px0_r) - DXW'(sx_cur);
    v0_nxt.dx2 = DXW'(scx_cur) - DXW'(sx_cur);
    v0_nxt.dy1 = DYW'(py0_r) - DYW'(sy_cur);
    v0_nxt.dy2 = DYW'(scy_cur) - DYW'(sy_cur);

    // check centered on the previous vertex
    pv_nxt.dx1 = DXW'(px1_r) - DXW'(px0_r);
    pv_nxt.dx2 = DXW'(x1_r) - DXW'(px0_r);
    pv_nxt.dy1 = DYW'(py1_r) - DYW'(py0_r);
    pv_nxt.dy2 = DYW'(y1_r) - DYW'(py0_r);

    if (fin) begin
      cnt_nxt = '0;
    end else if (idx == LAST_IDX) begin
      cnt_nxt = idx;
    end else begin
      cnt_nxt = idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      s2_flags_r <= '0;
    end else begin
      s2_flags_r <= flags_nxt;
      if (v1_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_v0_r <= v0_nxt;
    s2_pv_r <= pv_nxt;
    if (v1_r) begin
      sx_r   <= sx_cur;
      sy_r   <= sy_cur;
      scx_r  <= scx_cur;
      scy_r  <= scy_cur;
      minx_r <= minx_n;
      maxx_r <= maxx_n;
      miny_r <= miny_n;
      maxy_r <= maxy_n;
      px1_r  <= px0_r;
      py1_r  <= py0_r;
      px0_r  <= x1_r;
      py0_r  <= y1_r;
    end
  end

  assign busy     = {v1_r, v0_r};
  assign s2_flags = s2_flags_r;
  assign s2_v0    = s2_v0_r;
  assign s2_pv    = s2_pv_r;

  `ASSERT_NEXT(a_final_restarts, clk, rst_n, v1_r && fin1_r, cnt_r == '0)
  `ASSERT_ALWAYS(a_index_saturates, clk, rst_n, cnt_r <= LAST_IDX)

endmodule

// ===== hw/rtl/pvcc_excursion.sv =====
`timescale 1ns / 1ps

module pvcc_excursion import pvcc_pkg::*; (
  input  logic   clk,
  input  delta_t d,
  output logic   non_area,
  output logic   zero_angle
);

  logic signed [PW-1:0] p1_r, p2_r, p1_nxt, p2_nxt;
  logic dy0_r, dx0_r, ssx_r, ssy_r, na_r;
  logic dy0, dx0, ssx, ssy, na;

  always_comb begin
    dy0 = (d.dy1 == '0) && (d.dy2 == '0);
    dx0 = (d.dx1 == '0) && (d.dx2 == '0);
    ssx = (d.dx1 != '0) && (d.dx2 != '0) && (d.dx1[DXW-1] == d.dx2[DXW-1]);
    ssy = (d.dy1 != '0) && (d.dy2 != '0) && (d.dy1[DYW-1] == d.dy2[DYW-1]);
    // equal offsets from the center mean left and right coincide
    na  = (d.dx1 == d.dx2) && (d.dy1 == d.dy2);
  end

  assign p1_nxt = d.dy1 * d.dx2;
  assign p2_nxt = d.dx1 * d.dy2;

  always_ff @(posedge clk) begin
    p1_r  <= p1_nxt;
    p2_r  <= p2_nxt;
    dy0_r <= dy0;
    dx0_r <= dx0;
    ssx_r <= ssx;
    ssy_r <= ssy;
    na_r  <= na;
  end

  always_comb begin
    non_area = na_r;
    priority if (dy0_r) begin
      zero_angle = ssx_r;
    end else if (dx0_r) begin
      zero_angle = ssy_r;
    end else begin
      zero_angle = ssx_r && ssy_r && (p1_r == p2_r);
    end
  end

endmodule

// ===== hw/rtl/pvcc_report_queue.sv =====
`timescale 1ns / 1ps
`include "polygon_vertex_consistency_check_core_macros.svh"

module pvcc_report_queue import pvcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  rpt_entry_t        push_entry,
  output logic [QAW:0]      count,
  pvcc_out_if.source        out_rpt
);

  rpt_entry_t       mem_r [QDEPTH];
  logic [QAW-1:0]   wr_r, rd_r;
  logic [QAW:0]     cnt_r;
  logic [MASKW-1:0] sent_r, sent_nxt;
  rpt_entry_t       head;
  logic [MASKW-1:0] left_m, low;
  logic [MBW-1:0]   pos;
  rpt_fields_t      fields;
  logic             beat, last, pop;

  always_comb begin
    head   = mem_r[rd_r];
    left_m = head.mask & ~sent_r;
    low    = left_m & (~left_m + MASKW'(1));
    pos    = '0;
    for (int i = 0; i < MASKW; i++) begin
      if (low[i]) begin
        pos = MBW'(i);
      end
    end
    fields = decode_report(pos, head.idx);
    last   = ((left_m & ~low) == '0);
    beat   = out_rpt.valid && out_rpt.ready;
    pop    = beat && last;
    if (pop) begin
      sent_nxt = '0;
    end else if (beat) begin
      sent_nxt = sent_r | low;
    end else begin
      sent_nxt = sent_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
      sent_r <= '0;
    end else begin
      sent_r <= sent_nxt;
      cnt_r  <= cnt_r + (QAW+1)'(push_i) - (QAW+1)'(pop);
      if (push_i) begin
        wr_r <= wr_r + QAW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QAW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  assign count                = cnt_r;
  assign out_rpt.valid        = (cnt_r != '0);
  assign out_rpt.report_kind  = fields.kind;
  assign out_rpt.left_index   = fields.left;
  assign out_rpt.center_index = fields.center;
  assign out_rpt.right_index  = fields.right;
  assign out_rpt.run_end      = last;

  `ASSERT_ALWAYS(a_q_bound, clk, rst_n, cnt_r <= (QAW+1)'(QDEPTH))
  `ASSERT_IMPLIES(a_q_head_live, clk, rst_n, cnt_r != '0, left_m != '0)
  `ASSERT_IMPLIES(a_q_room, clk, rst_n, push_i, (cnt_r != (QAW+1)'(QDEPTH)) || pop)

endmodule

// ===== hw/rtl/polygon_vertex_consistency_check_core.sv =====
`timescale 1ns / 1ps

// Polygon vertex checker: takes one vertex per cycle and, after a pipeline (input
// register, date-line wrap, polygon state and differences, cross products), files
// the vertex's reports into an 8-entry report queue that drives the result channel
// one report per beat. Each queue entry holds all reports of one vertex; a vertex
// with k reports holds the output for k beats. The input channel stalls only while
// queued entries plus vertices in flight reach the queue depth, so with sparse
// reports the sustained rate is one vertex per clock. Configuration is written
// through cfg_we/cfg_index/cfg_data; the user must do so only while no vertex is
// in flight, and the block itself does not enforce it.
module polygon_vertex_consistency_check_core import pvcc_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFGIW-1:0] cfg_index,
  input  logic [CFGDW-1:0] cfg_data,
  pvcc_in_if.sink          in_vtx,
  pvcc_out_if.source       out_rpt
);

  cfg_t             cfg_r;
  logic             in_fire;
  logic [1:0]       busy;
  flags_t           s2_flags, s3_flags_r;
  delta_t           s2_v0, s2_pv;
  logic             v0_na, v0_za, pv_na, pv_za;
  rpt_entry_t       entry;
  logic             push;
  logic [QAW:0]     q_count;
  logic [QAW+1:0]   occ;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_WRAP_ENABLE:    cfg_r.wrap_enable    <= cfg_data[0];
        CFG_DATE_LONGITUDE: cfg_r.date_longitude <= cfg_data[LONW-1:0];
        CFG_BOX_WEST:       cfg_r.box_west       <= cfg_data[LONW-1:0];
        CFG_BOX_EAST:       cfg_r.box_east       <= cfg_data[LONW-1:0];
        CFG_BOX_SOUTH:      cfg_r.box_south      <= cfg_data[LATW-1:0];
        CFG_BOX_NORTH:      cfg_r.box_north      <= cfg_data[LATW-1:0];
        CFG_POLAR_CAP:      cfg_r.polar_cap      <= cfg_data[0];
        CFG_REGION_CHECK:   cfg_r.region_check   <= cfg_data[0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // reserve a queue slot for every vertex still in the pipeline
  assign occ = (QAW+2)'(q_count) + (QAW+2)'(busy[0]) + (QAW+2)'(busy[1]) +
               (QAW+2)'(s2_flags.valid) + (QAW+2)'(s3_flags_r.valid);
  assign in_vtx.ready = (occ < (QAW+2)'(QDEPTH));
  assign in_fire      = in_vtx.valid && in_vtx.ready;

  pvcc_track #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_fire  (in_fire),
    .in_lon   (in_vtx.lon_micro),
    .in_lat   (in_vtx.lat_micro),
    .in_first (in_vtx.first_vertex),
    .in_fin   (in_vtx.final_vertex),
    .busy     (busy),
    .s2_flags (s2_flags),
    .s2_v0    (s2_v0),
    .s2_pv    (s2_pv)
  );

  pvcc_excursion u_exc_v0 (
    .clk        (clk),
    .d          (s2_v0),
    .non_area   (v0_na),
    .zero_angle (v0_za)
  );

  pvcc_excursion u_exc_pv (
    .clk        (clk),
    .d          (s2_pv),
    .non_area   (pv_na),
    .zero_angle (pv_za)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_flags_r <= '0;
    end else begin
      s3_flags_r <= s2_flags;
    end
  end

  always_comb begin
    entry.idx            = s3_flags_r.idx;
    entry.mask           = '0;
    entry.mask[MB_DUP]   = s3_flags_r.dup;
    entry.mask[MB_OPEN]  = s3_flags_r.open;
    entry.mask[MB_BOX]   = s3_flags_r.box;
    entry.mask[MB_V0_NA] = s3_flags_r.v0_en && v0_na;
    entry.mask[MB_V0_ZA] = s3_flags_r.v0_en && v0_za;
    entry.mask[MB_PV_NA] = s3_flags_r.pv_en && pv_na;
    entry.mask[MB_PV_ZA] = s3_flags_r.pv_en && pv_za;
    // drop vertices that raise nothing
    push = s3_flags_r.valid && (entry.mask != '0);
  end

  pvcc_report_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_entry (entry),
    .count      (q_count),
    .out_rpt    (out_rpt)
  );

endmodule

// ===== test/polygon_vertex_consistency_check_core_test.sv =====
`timescale 1ns / 1ps

module polygon_vertex_consistency_check_core_test;
  import pvcc_pkg::*;

  localparam longint TURN_MICRO = 360000000;
  localparam longint POLE_MICRO = 90000000;

  typedef struct {
    rpt_kind_t     kind;
    logic [IW-1:0] left;
    logic [IW-1:0] center;
    logic [IW-1:0] right;
    logic          run_end;
  } report_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFGIW-1:0] cfg_index;
  logic [CFGDW-1:0] cfg_data;

  pvcc_in_if  in_vtx();
  pvcc_out_if out_rpt();

  polygon_vertex_consistency_check_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_vtx    (in_vtx),
    .out_rpt   (out_rpt)
  );

  // Checker copy of the registers
  bit                     wrap_en;
  logic signed [LONW-1:0] date_lon;
  logic signed [LONW-1:0] hdr_west;
  logic signed [LONW-1:0] hdr_east;
  logic signed [LATW-1:0] hdr_south;
  logic signed [LATW-1:0] hdr_north;
  bit                     polar_en;
  bit                     region_en;

  // Checker copy of the polygon state
  logic [IW-1:0]          vtx_count;
  logic signed [XW-1:0]   start_x, second_x;
  logic signed [LATW-1:0] start_y, second_y;
  logic signed [XW-1:0]   prev_x [2];
  logic signed [LATW-1:0] prev_y [2];
  logic signed [XW-1:0]   min_x, max_x;
  logic signed [YBW-1:0]  min_y, max_y;

  report_t expected_reports[$];
  report_t vertex_reports[$];
  int      mismatch_count = 0;
  int      sent_items = 0;
  bit      quiet = 1'b0;
  int      hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bool_same_sign(longint a, longint b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  function automatic void add_report(rpt_kind_t kind, logic [IW-1:0] l, logic [IW-1:0] c,
                                     logic [IW-1:0] r);
    report_t e;
    e.kind    = kind;
    e.left    = l;
    e.center  = c;
    e.right   = r;
    e.run_end = 1'b0;
    vertex_reports.push_back(e);
  endfunction

  // Non-area when the neighbors coincide; zero-angle when all three are collinear
  // and the center lies outside the neighbors.
  function automatic void check_excursion(longint lx, longint ly, longint cx, longint cy,
                                          longint rx, longint ry, logic [IW-1:0] li,
                                          logic [IW-1:0] ci, logic [IW-1:0] ri);
    longint dx1, dx2, dy1, dy2;
    bit     hit;
    dx1 = lx - cx;
    dx2 = rx - cx;
    dy1 = ly - cy;
    dy2 = ry - cy;
    hit = 1'b0;
    if (lx == rx && ly == ry) add_report(RPT_NON_AREA, li, ci, ri);
    if (dy1 == 0 && dy2 == 0) hit = bool_same_sign(dx1, dx2);
    else if (dx1 == 0 && dx2 == 0) hit = bool_same_sign(dy1, dy2);
    else if (bool_same_sign(dx1, dx2) && bool_same_sign(dy1, dy2))
      hit = (dy1 * dx2 == dx1 * dy2);
    if (hit) add_report(RPT_ZERO_ANGLE, li, ci, ri);
  endfunction

  function automatic void predict_vertex(logic signed [LONW-1:0] lon,
                                         logic signed [LATW-1:0] lat,
                                         bit is_first_in, bit is_last);
    longint        x, y, ymin;
    bit            is_first;
    logic [IW-1:0] idx;
    int            nxt;
    x = lon;
    y = lat;
    is_first = is_first_in || (vtx_count == '0);
    idx = is_first ? '0 : vtx_count;
    vertex_reports.delete();

    if (wrap_en && x > date_lon) x -= TURN_MICRO;

    if (is_first) begin
      min_x = XW'(TURN_MICRO);
      max_x = XW'(-TURN_MICRO);
      min_y = YBW'(TURN_MICRO);
      max_y = YBW'(-TURN_MICRO);
      start_x = XW'(x);
      start_y = LATW'(y);
    end
    if (idx == IW'(1)) begin
      second_x = XW'(x);
      second_y = LATW'(y);
    end
    if (x < min_x) min_x = XW'(x);
    if (x > max_x) max_x = XW'(x);
    if (y < min_y) min_y = YBW'(y);
    if (y > max_y) max_y = YBW'(y);

    if (idx > 0 && x == prev_x[0] && y == prev_y[0]) add_report(RPT_DUPLICATE, '0, idx, '0);

    if (is_last) begin
      ymin = polar_en ? -POLE_MICRO : longint'(min_y);
      if (!(x == start_x && y == start_y)) add_report(RPT_NOT_CLOSED, '0, idx, '0);
      if (region_en && !(min_x == hdr_west && max_x == hdr_east && ymin == hdr_south &&
                         max_y == hdr_north))
        add_report(RPT_BOX_MISMATCH, '0, idx, '0);
      // Vertex 0 takes the penultimate vertex as its left neighbor
      if (idx >= 1)
        check_excursion(prev_x[0], prev_y[0], start_x, start_y, second_x, second_y,
                        idx - IW'(1), '0, IW'(1));
    end
    if (idx >= 2)
      check_excursion(prev_x[1], prev_y[1], prev_x[0], prev_y[0], x, y,
                      idx - IW'(2), idx - IW'(1), idx);

    prev_x[1] = prev_x[0];
    prev_y[1] = prev_y[0];
    prev_x[0] = XW'(x);
    prev_y[0] = LATW'(y);

    if (is_last) vtx_count = '0;
    else begin
      nxt = int'(idx) + 1;
      vtx_count = (nxt < DEF_MAX_VERTICES) ? IW'(nxt) : IW'(DEF_MAX_VERTICES - 1);
    end

    if (vertex_reports.size() > 0) vertex_reports[vertex_reports.size() - 1].run_end = 1'b1;
    foreach (vertex_reports[i]) expected_reports.push_back(vertex_reports[i]);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic longint grid_point(longint lo, longint hi);
    return lo + (hi - lo) * longint'($urandom_range(0, 4)) / 4;
  endfunction

  task automatic send_vertex(input longint lon, input longint lat, input bit is_first,
                             input bit is_last);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_vtx.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_vtx.valid        = 1'b1;
    in_vtx.lon_micro    = LONW'(lon);
    in_vtx.lat_micro    = LATW'(lat);
    in_vtx.first_vertex = is_first;
    in_vtx.final_vertex = is_last;
    do @(posedge clk); while (!in_vtx.ready);
    predict_vertex(in_vtx.lon_micro, in_vtx.lat_micro, is_first, is_last);
    sent_items++;
  endtask

  // Drop valid, drain every expected report, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_vtx.valid = 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input longint value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = which;
    cfg_data  = CFGDW'(value);
    @(posedge clk);
    case (which)
      CFG_WRAP_ENABLE:    wrap_en   = value[0];
      CFG_DATE_LONGITUDE: date_lon  = LONW'(value);
      CFG_BOX_WEST:       hdr_west  = LONW'(value);
      CFG_BOX_EAST:       hdr_east  = LONW'(value);
      CFG_BOX_SOUTH:      hdr_south = LATW'(value);
      CFG_BOX_NORTH:      hdr_north = LATW'(value);
      CFG_POLAR_CAP:      polar_en  = value[0];
      CFG_REGION_CHECK:   region_en = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(input bit wrap, input longint date, input longint west,
                           input longint east, input longint south, input longint north,
                           input bit polar, input bit region);
    settle();
    write_reg(CFG_WRAP_ENABLE, wrap);
    write_reg(CFG_DATE_LONGITUDE, date);
    write_reg(CFG_BOX_WEST, west);
    write_reg(CFG_BOX_EAST, east);
    write_reg(CFG_BOX_SOUTH, south);
    write_reg(CFG_BOX_NORTH, north);
    write_reg(CFG_POLAR_CAP, polar);
    write_reg(CFG_REGION_CHECK, region);
  endtask

  // Mostly closed polygon on a coarse grid so that repeats and collinear runs are common.
  task automatic send_random_polygon(input longint gw, input longint ge, input longint gs,
                                     input longint gn);
    int     n, r;
    longint xs[$];
    longint ys[$];
    longint x, y;
    bit     is_first;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      x = grid_point(gw, ge);
      y = grid_point(gs, gn);
      if (k == 0 && r < 5) begin
        x = gw;
        y = gs;
      end else if (k > 0 && k == n / 2 && r < 5) begin
        x = ge;
        y = gn;
      end else if (k > 0 && r < 2) begin
        x = xs[k-1];
        y = ys[k-1];
      end else if (k > 1 && r < 4) begin
        x = xs[k-2];
        y = ys[k-2];
      end
      if (k == n - 1 && k > 0 && $urandom_range(0, 6) != 0) begin
        x = xs[0];
        y = ys[0];
      end
      xs.push_back(x);
      ys.push_back(y);
      is_first = (k == 0) && ($urandom_range(0, 4) != 0);
      send_vertex(x, y, is_first, k == n - 1);
    end
  endtask

  task automatic send_noise();
    int count;
    count = $urandom_range(1, 3);
    repeat (count)
      send_vertex(longint'($urandom_range(0, 720000000)) - TURN_MICRO,
                  longint'($urandom_range(0, 180000000)) - POLE_MICRO,
                  $urandom_range(0, 1), $urandom_range(0, 3) == 0);
  endtask

  task automatic run_random_phase(input longint gw, input longint ge, input longint gs,
                                  input longint gn, input int items);
    int stop_at;
    stop_at = sent_items + items;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 5) == 0) send_noise();
      else send_random_polygon(gw, ge, gs, gn);
    end
  endtask

  // Reset registers: duplicates, excursions, open polygons, tiny polygons.
  task automatic test_shape_checks();
    send_vertex(-TURN_MICRO, -POLE_MICRO, 1, 0);
    send_vertex(TURN_MICRO, POLE_MICRO, 0, 0);
    send_vertex(TURN_MICRO, -POLE_MICRO, 0, 0);
    send_vertex(-TURN_MICRO, -POLE_MICRO, 0, 1);
    // horizontal zero-angle, then a duplicate
    send_vertex(0, 0, 1, 0);
    send_vertex(5, 0, 0, 0);
    send_vertex(3, 0, 0, 0);
    send_vertex(3, 0, 0, 0);
    send_vertex(0, 0, 0, 1);
    // implicit start; diagonal zero-angle, non-area, left open
    send_vertex(0, 0, 0, 0);
    send_vertex(4, 4, 0, 0);
    send_vertex(2, 2, 0, 0);
    send_vertex(4, 4, 0, 0);
    send_vertex(1, 1, 0, 1);
    // single vertex polygons
    send_vertex(7, 7, 1, 1);
    send_vertex(-7, 9, 0, 1);
    // two vertex polygons
    send_vertex(10, 0, 1, 0);
    send_vertex(20, 0, 0, 1);
    send_vertex(10, 0, 1, 0);
    send_vertex(10, 0, 0, 1);
  endtask

  task automatic test_box_report();
    configure(0, 0, -1000, 3000, -2000, 2000, 0, 1);
    send_vertex(-1000, -2000, 1, 0);
    send_vertex(3000, -2000, 0, 0);
    send_vertex(3000, 2000, 0, 0);
    send_vertex(-1000, -2000, 0, 1);
    // open, box mismatch and both excursions twice at the last vertex
    send_vertex(0, 0, 1, 0);
    send_vertex(5, 0, 0, 0);
    send_vertex(3, 0, 0, 0);
    send_vertex(5, 0, 0, 0);
    send_vertex(3, 0, 0, 1);
  endtask

  task automatic test_date_line_wrap();
    configure(1, 180000000, -179000000, 180000000, -10000000, 10000000, 0, 1);
    send_vertex(179000000, 0, 1, 0);
    send_vertex(181000000, 10000000, 0, 0);
    send_vertex(180000000, -10000000, 0, 0);
    send_vertex(179000000, 0, 0, 1);
  endtask

  task automatic test_random_polygons();
    configure(0, 0, -TURN_MICRO, TURN_MICRO, -POLE_MICRO, POLE_MICRO, 0, 1);
    run_random_phase(-TURN_MICRO, TURN_MICRO, -POLE_MICRO, POLE_MICRO, 48);
    configure(1, TURN_MICRO, -1000, 3000, -POLE_MICRO, 2000, 1, 1);
    run_random_phase(-1000, 3000, -2000, 2000, 48);
    configure(1, -TURN_MICRO, -TURN_MICRO, 0, -POLE_MICRO, POLE_MICRO, 0, 1);
    run_random_phase(-TURN_MICRO, TURN_MICRO, -POLE_MICRO, POLE_MICRO, 48);
    configure(1, 0, 0, 0, 0, 0, 0, 0);
    quiet = 1'b1;
    run_random_phase(-2000, 2000, -1000, 1000, 48);
    quiet = 1'b0;
    configure(0, 0, TURN_MICRO, -TURN_MICRO, POLE_MICRO, -POLE_MICRO, 1, 1);
    run_random_phase(0, 8, 0, 8, 48);
  endtask

  // Hold the output off while a run of repeated points fills the report queue.
  task automatic test_output_hold_off();
    longint x, y;
    configure(0, 0, 0, 0, 0, 0, 0, 0);
    x = longint'($urandom_range(0, 720000000)) - TURN_MICRO;
    y = longint'($urandom_range(0, 180000000)) - POLE_MICRO;
    hold_cycles = 300;
    quiet = 1'b1;
    send_vertex(x, y, 1, 0);
    repeat (40) send_vertex(x, y, 0, 0);
    send_vertex(x, y, 0, 1);
    quiet = 1'b0;
    while (hold_cycles > 0) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_rpt.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_rpt.ready = 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_rpt.ready = 1'b0;
        stall_left--;
      end else begin
        out_rpt.ready = 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_rpt.valid && out_rpt.ready) begin
      if (expected_reports.size() == 0) begin
        $error("report beat with nothing expected: kind %0d center %0d",
               out_rpt.report_kind, out_rpt.center_index);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        if (out_rpt.report_kind !== want.kind) begin
          $error("report_kind: expected %0d, got %0d", want.kind, out_rpt.report_kind);
          mismatch_count++;
        end
        if (out_rpt.left_index !== want.left) begin
          $error("left_index: expected %0d, got %0d", want.left, out_rpt.left_index);
          mismatch_count++;
        end
        if (out_rpt.center_index !== want.center) begin
          $error("center_index: expected %0d, got %0d", want.center, out_rpt.center_index);
          mismatch_count++;
        end
        if (out_rpt.right_index !== want.right) begin
          $error("right_index: expected %0d, got %0d", want.right, out_rpt.right_index);
          mismatch_count++;
        end
        if (out_rpt.run_end !== want.run_end) begin
          $error("run_end: expected %0d, got %0d", want.run_end, out_rpt.run_end);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("polygon_vertex_consistency_check_core: mismatch");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_WRAP_ENABLE;
    cfg_data            = '0;
    in_vtx.valid        = 1'b0;
    in_vtx.lon_micro    = '0;
    in_vtx.lat_micro    = '0;
    in_vtx.first_vertex = 1'b0;
    in_vtx.final_vertex = 1'b0;
    wrap_en   = 1'b0;
    date_lon  = '0;
    hdr_west  = '0;
    hdr_east  = '0;
    hdr_south = '0;
    hdr_north = '0;
    polar_en  = 1'b0;
    region_en = 1'b0;
    vtx_count = '0;
    start_x   = '0;
    start_y   = '0;
    second_x  = '0;
    second_y  = '0;
    prev_x[0] = '0;
    prev_x[1] = '0;
    prev_y[0] = '0;
    prev_y[1] = '0;
    min_x     = XW'(TURN_MICRO);
    max_x     = XW'(-TURN_MICRO);
    min_y     = YBW'(TURN_MICRO);
    max_y     = YBW'(-TURN_MICRO);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_shape_checks();
    test_box_report();
    test_date_line_wrap();
    test_random_polygons();
    test_output_hold_off();
    settle();

    if (mismatch_count == 0) $display("polygon_vertex_consistency_check_core: match");
    else $display("polygon_vertex_consistency_check_core: mismatch");
    $finish;
  end

endmodule
